// ----- sv/dtf_pkg.sv -----
package dtf_pkg;

    localparam int CH_W       = 8;
    localparam int VALUE_W    = 32;
    localparam int FNUM_W     = 30;
    localparam int FCNT_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // One finished parse, handed from the parser to the divider.
    typedef struct packed {
        logic                negative;
        logic                clamped;
        logic [VALUE_W-1:0]  int_val;
        logic [FNUM_W-1:0]   frac_num;
        logic [FCNT_W-1:0]   frac_cnt;
    } dtf_job_t;

    function automatic logic [FNUM_W-1:0] pow10(input logic [FCNT_W-1:0] n);
        logic [FNUM_W-1:0] r;
        case (n)
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/dtf_in_if.sv -----
interface dtf_in_if;
    import dtf_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

// ----- sv/dtf_out_if.sv -----
interface dtf_out_if;
    import dtf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink   (input valid, input value, input saturated, output ready);
endinterface

// ----- sv/dtf_front.sv -----
module dtf_front #(
    parameter int INT_BITS        = 15,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    dtf_in_if.sink            text,
    input  logic              q_full,
    output logic              q_push,
    output dtf_pkg::dtf_job_t q_data
);
    import dtf_pkg::*;

    localparam int IW = INT_BITS + 4;
    localparam logic [IW-1:0]     INT_MAX = IW'((64'd1 << INT_BITS) - 64'd1);
    localparam logic [FCNT_W-1:0] MAX_CNT = FCNT_W'(MAX_FRAC_DIGITS);

    phase_t                phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [INT_BITS-1:0]   int_reg, int_next;
    logic                  clamp_reg, clamp_next;
    logic [FNUM_W-1:0]     fnum_reg, fnum_next;
    logic [FCNT_W-1:0]     fcnt_reg, fcnt_next;

    logic                  accept;
    phase_t                ph_eff;
    logic                  neg_eff, clamp_eff;
    logic [INT_BITS-1:0]   int_eff;
    logic [FNUM_W-1:0]     fnum_eff;
    logic [FCNT_W-1:0]     fcnt_eff;
    logic                  is_ws, is_minus, is_dot, is_digit;
    logic [3:0]            digit;
    logic [IW-1:0]         int_ext, int_x10;
    logic [FNUM_W-1:0]     fnum_x10;
    logic                  term;

    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;

    // A first character drops whatever parse was running.
    assign ph_eff    = text.first ? PH_SKIP : phase_reg;
    assign neg_eff   = text.first ? 1'b0 : neg_reg;
    assign clamp_eff = text.first ? 1'b0 : clamp_reg;
    assign int_eff   = text.first ? '0 : int_reg;
    assign fnum_eff  = text.first ? '0 : fnum_reg;
    assign fcnt_eff  = text.first ? '0 : fcnt_reg;

    assign is_ws    = text.ch inside {CH_SPACE, CH_FF, CH_LF, CH_CR, CH_TAB, CH_VT, CH_PLUS};
    assign is_minus = text.ch == CH_MINUS;
    assign is_dot   = text.ch == CH_DOT;
    assign is_digit = text.ch inside {[CH_ZERO:CH_NINE]};
    assign digit    = text.ch[3:0];

    assign int_ext  = IW'(int_eff);
    assign int_x10  = (int_ext << 3) + (int_ext << 1) + IW'(digit);
    assign fnum_x10 = (fnum_eff << 3) + (fnum_eff << 1) + FNUM_W'(digit);

    always_comb
    begin
        case (ph_eff)
            PH_SKIP: term = !(is_ws || is_minus || is_digit || is_dot);
            PH_INT:  term = !(is_digit || is_dot);
            PH_FRAC: term = !is_digit;
            default: term = 1'b0;
        endcase
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = ph_eff;
            if (term)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                case (ph_eff)
                    PH_SKIP:
                    begin
                        if (is_minus || is_digit)
                        begin
                            phase_next = PH_INT;
                        end
                        else if (is_dot)
                        begin
                            phase_next = PH_FRAC;
                        end
                    end
                    PH_INT:
                    begin
                        if (is_dot)
                        begin
                            phase_next = PH_FRAC;
                        end
                    end
                    default: phase_next = ph_eff;
                endcase
            end
        end
    end

    // Accumulator updates and queue push.
    always_comb
    begin
        neg_next   = neg_reg;
        int_next   = int_reg;
        clamp_next = clamp_reg;
        fnum_next  = fnum_reg;
        fcnt_next  = fcnt_reg;
        q_push     = 1'b0;
        if (accept)
        begin
            neg_next   = neg_eff;
            int_next   = int_eff;
            clamp_next = clamp_eff;
            fnum_next  = fnum_eff;
            fcnt_next  = fcnt_eff;
            q_push     = term;
            if (!term)
            begin
                case (ph_eff)
                    PH_SKIP, PH_INT:
                    begin
                        if (is_minus)
                        begin
                            neg_next = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            if (int_x10 > INT_MAX)
                            begin
                                int_next   = INT_MAX[INT_BITS-1:0];
                                clamp_next = 1'b1;
                            end
                            else
                            begin
                                int_next = int_x10[INT_BITS-1:0];
                            end
                        end
                    end
                    PH_FRAC:
                    begin
                        if (fcnt_eff < MAX_CNT)
                        begin
                            fnum_next = fnum_x10;
                            fcnt_next = fcnt_eff + FCNT_W'(1);
                        end
                    end
                    default: neg_next = neg_eff;
                endcase
            end
        end
    end

    always_comb
    begin
        q_data.negative = neg_eff;
        q_data.clamped  = clamp_eff;
        q_data.int_val  = VALUE_W'(int_eff);
        q_data.frac_num = fnum_eff;
        q_data.frac_cnt = fcnt_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            clamp_reg <= 1'b0;
            fnum_reg  <= '0;
            fcnt_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            int_reg   <= int_next;
            clamp_reg <= clamp_next;
            fnum_reg  <= fnum_next;
            fcnt_reg  <= fcnt_next;
        end
    end

endmodule

// ----- sv/dtf_queue.sv -----
module dtf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dtf_pkg::dtf_job_t push_data,
    output logic              full,
    input  logic              pop,
    output dtf_pkg::dtf_job_t pop_data,
    output logic              empty
);
    import dtf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dtf_job_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full     = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- sv/dtf_back.sv -----
module dtf_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    output logic              q_pop,
    input  dtf_pkg::dtf_job_t q_data,
    dtf_out_if.source         result
);
    import dtf_pkg::*;

    localparam int STEP_W = $clog2(FRAC_BITS);

    back_state_t            state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [FNUM_W-1:0]      rem_reg, rem_next;
    logic [FNUM_W-1:0]      div_reg, div_next;
    logic [FRAC_BITS-1:0]   quo_reg, quo_next;
    logic                   neg_reg, neg_next;
    logic                   clamp_reg, clamp_next;
    logic [VALUE_W-1:0]     int_reg, int_next;
    logic                   ovalid_reg, ovalid_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic                   sat_reg, sat_next;

    logic                   load_job, div_step, load_out, out_free, last_step;
    logic [FNUM_W:0]        rem_x2, trial;
    logic                   fits;
    logic [VALUE_W-1:0]     mag;

    assign out_free  = !ovalid_reg || result.ready;
    assign last_step = step_reg == STEP_W'(FRAC_BITS - 1);

    // Restoring division: the remainder stays below the divisor, so one
    // compare and subtract yields each quotient bit.
    assign rem_x2 = {rem_reg, 1'b0};
    assign trial  = rem_x2 - {1'b0, div_reg};
    assign fits   = rem_x2 >= {1'b0, div_reg};

    assign mag = (int_reg << FRAC_BITS) + VALUE_W'(quo_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (last_step)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        load_job = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE: load_job = !q_empty;
            BK_DIV:  div_step = 1'b1;
            BK_DONE: load_out = out_free;
            default: load_job = 1'b0;
        endcase
    end

    assign q_pop = load_job;

    always_comb
    begin
        step_next  = step_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        clamp_next = clamp_reg;
        int_next   = int_reg;
        if (load_job)
        begin
            step_next  = '0;
            rem_next   = q_data.frac_num;
            div_next   = pow10(q_data.frac_cnt);
            quo_next   = '0;
            neg_next   = q_data.negative;
            clamp_next = q_data.clamped;
            int_next   = q_data.int_val;
        end
        else if (div_step)
        begin
            step_next = step_reg + STEP_W'(1);
            rem_next  = fits ? trial[FNUM_W-1:0] : rem_x2[FNUM_W-1:0];
            quo_next  = {quo_reg[FRAC_BITS-2:0], fits};
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        value_next  = value_reg;
        sat_next    = sat_reg;
        if (ovalid_reg && result.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (load_out)
        begin
            ovalid_next = 1'b1;
            value_next  = neg_reg ? (VALUE_W'(0) - mag) : mag;
            sat_next    = clamp_reg;
        end
    end

    assign result.valid     = ovalid_reg;
    assign result.value     = value_reg;
    assign result.saturated = sat_reg;

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
        clamp_reg <= clamp_next;
        int_reg   <= int_next;
        value_reg <= value_next;
        sat_reg   <= sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ----- sv/decimal_text_to_fixed_unit.sv -----
// Parses ASCII decimal text, one character per transaction, into a signed fixed-point
// value with INT_BITS integer and FRAC_BITS fraction bits (Q15.16 by default). Set first
// on the opening character of each string; leading whitespace and '+' are skipped, then
// an optional '-', integer digits, an optional '.' and fraction digits are taken, and the
// first other character (NUL included) ends the string and produces one result. The
// parser takes a character every cycle. Each finished string then passes through a
// two-entry queue to a bit-serial divider, which takes the string from the queue, forms
// the fraction bit by bit and then loads the output register once that register is free;
// it takes no new string from the queue before then. Input stalls on any character while
// both queue entries are occupied. The integer part clamps at 2^INT_BITS - 1 and sets
// saturated; fraction digits beyond MAX_FRAC_DIGITS are ignored and the fraction is
// truncated.
module decimal_text_to_fixed_unit #(
    parameter int FRAC_BITS       = 16,
    parameter int INT_BITS        = 15,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic      clk,
    input  logic      rst_n,
    dtf_in_if.sink    text,
    dtf_out_if.source result
);
    import dtf_pkg::*;

    logic     push, pop, full, empty;
    dtf_job_t push_data, pop_data;

    dtf_front #(
        .INT_BITS        (INT_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_full (full),
        .q_push (push),
        .q_data (push_data)
    );

    dtf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    dtf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (empty),
        .q_pop   (pop),
        .q_data  (pop_data),
        .result  (result)
    );

endmodule

// ----- verif/decimal_text_to_fixed_unit_tb.sv -----
module decimal_text_to_fixed_unit_tb;
    import dtf_pkg::*;

    localparam int FRAC_BITS       = 16;
    localparam int INT_BITS        = 15;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam logic [63:0] INT_LIMIT = (64'd1 << INT_BITS) - 64'd1;

    typedef logic [CH_W-1:0] char_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
    } fixed_number_t;

    logic clk;
    logic rst_n;

    dtf_in_if  text_if();
    dtf_out_if result_if();

    decimal_text_to_fixed_unit #(
        .FRAC_BITS       (FRAC_BITS),
        .INT_BITS        (INT_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (result_if)
    );

    // Shadow copy of the parser state.
    phase_t              parse_phase;
    logic                parse_negative;
    logic [INT_BITS-1:0] parse_int;
    logic                parse_clamped;
    logic [FNUM_W-1:0]   parse_frac_num;
    logic [FCNT_W-1:0]   parse_frac_cnt;

    fixed_number_t pending_numbers[$];
    char_t         text_buf[$];

    int  error_count;
    int  chars_sent;
    int  strings_started;
    int  numbers_seen;
    int  saturated_seen;
    int  negative_seen;
    bit  keep_text_busy;
    bit  keep_ready_high;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #10_000_000;
        $display("decimal_text_to_fixed_unit test failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (error_count < 30)
            $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic bit is_blank(input char_t c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR || c == CH_PLUS;
    endfunction

    function automatic bit is_digit(input char_t c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic clear_parse();
        parse_negative = 1'b0;
        parse_int      = '0;
        parse_clamped  = 1'b0;
        parse_frac_num = '0;
        parse_frac_cnt = '0;
    endtask

    task automatic take_int_digit(input char_t c);
        logic [63:0] grown;
        grown = 64'(parse_int) * 64'd10 + 64'(c - CH_ZERO);
        if (grown > INT_LIMIT)
        begin
            parse_int     = INT_LIMIT[INT_BITS-1:0];
            parse_clamped = 1'b1;
        end
        else
        begin
            parse_int = grown[INT_BITS-1:0];
        end
    endtask

    task automatic take_frac_digit(input char_t c);
        if (parse_frac_cnt < MAX_FRAC_DIGITS)
        begin
            parse_frac_num = parse_frac_num * FNUM_W'(10) + FNUM_W'(c - CH_ZERO);
            parse_frac_cnt = parse_frac_cnt + 1'b1;
        end
    endtask

    // Forms the Q value of the string that just ended and queues it.
    task automatic finish_number();
        logic [63:0]   scale;
        logic [63:0]   frac;
        logic [63:0]   magnitude;
        logic [63:0]   signed_bits;
        fixed_number_t number;
        frac  = '0;
        scale = 64'd1;
        if (parse_frac_cnt != 0)
        begin
            repeat (parse_frac_cnt) scale = scale * 64'd10;
            frac = (64'(parse_frac_num) << FRAC_BITS) / scale;
        end
        magnitude        = (64'(parse_int) << FRAC_BITS) + frac;
        signed_bits      = parse_negative ? (64'd0 - magnitude) : magnitude;
        number.value     = signed_bits[VALUE_W-1:0];
        number.saturated = parse_clamped;
        pending_numbers.push_back(number);
        parse_phase = PH_DONE;
    endtask

    task automatic advance_parse(input char_t c, input bit first);
        if (first)
        begin
            clear_parse();
            parse_phase = PH_SKIP;
            strings_started++;
        end
        case (parse_phase)
            PH_SKIP:
            begin
                if (is_blank(c))
                    ;
                else if (c == CH_MINUS)
                begin
                    parse_negative = 1'b1;
                    parse_phase    = PH_INT;
                end
                else if (is_digit(c))
                begin
                    take_int_digit(c);
                    parse_phase = PH_INT;
                end
                else if (c == CH_DOT)
                    parse_phase = PH_FRAC;
                else
                    finish_number();
            end
            PH_INT:
            begin
                if (is_digit(c))
                    take_int_digit(c);
                else if (c == CH_DOT)
                    parse_phase = PH_FRAC;
                else
                    finish_number();
            end
            PH_FRAC:
            begin
                if (is_digit(c))
                    take_frac_digit(c);
                else
                    finish_number();
            end
            default:
                ;
        endcase
    endtask

    task automatic send_char(input char_t c, input bit first);
        int gap;
        gap = 0;
        if (!keep_text_busy && $urandom_range(0, 99) < 30)
            gap = random_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            text_if.valid = 1'b0;
            text_if.ch    = char_t'($urandom);
            text_if.first = 1'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        text_if.valid = 1'b1;
        text_if.ch    = c;
        text_if.first = first;
        do
            @(posedge clk);
        while (text_if.ready !== 1'b1);
        advance_parse(c, first);
        chars_sent++;
    endtask

    task automatic text_idle();
        @(negedge clk);
        text_if.valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_numbers.size() != 0)
            @(posedge clk);
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(char_t'(s[i]));
    endtask

    task automatic send_text_buf();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == 0);
    endtask

    function automatic char_t random_blank();
        case ($urandom_range(0, 6))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            5:       return CH_CR;
            default: return CH_PLUS;
        endcase
    endfunction

    function automatic char_t random_digit();
        return CH_ZERO + char_t'($urandom_range(0, 9));
    endfunction

    // A byte that ends the parse right away when it opens a string.
    function automatic char_t random_stop_char();
        char_t c;
        do
            c = char_t'($urandom);
        while (is_blank(c) || is_digit(c) || c == CH_MINUS || c == CH_DOT);
        return c;
    endfunction

    task automatic test_directed_cases();
        // Tab, line feed, space and '+' skipped, then minus zero ended by NUL.
        text_buf.delete();
        text_buf = '{CH_TAB, CH_LF, CH_SPACE, CH_PLUS, CH_MINUS, CH_ZERO, 8'h00};
        send_text_buf();

        // Fraction only, with more digits than are kept; truncation gives all ones.
        text_buf.delete();
        text_buf = '{CH_FF, CH_VT, CH_CR};
        append_text(".9999999999");
        text_buf.push_back(8'hFF);
        send_text_buf();

        // Integer overflow, and a '+' after a digit ends the string.
        text_buf.delete();
        append_text("40000+");
        send_text_buf();

        // A second minus sign ends an empty number.
        text_buf.delete();
        text_buf = '{CH_MINUS, CH_MINUS};
        send_text_buf();

        // An unfinished string is dropped by the next first flag.
        send_char(CH_ZERO + 8'd7, 1'b1);
        send_char(CH_DOT, 1'b1);
        send_char(8'h80, 1'b0);

        // A byte while done is ignored.
        send_char(CH_ZERO + 8'd5, 1'b0);
        text_idle();
        wait_for_results();
    endtask

    // Single-byte strings back to back fill the result queue and stall the input.
    task automatic test_back_to_back_strings();
        keep_text_busy  = 1'b1;
        keep_ready_high = 1'b1;
        repeat (30) send_char(random_stop_char(), 1'b1);
        keep_ready_high = 1'b0;
        repeat (30)
        begin
            if ($urandom_range(0, 1))
                send_char(random_digit(), 1'b1);
            send_char(random_stop_char(), 1'b1);
        end
        keep_text_busy = 1'b0;
        text_idle();
        wait_for_results();
    endtask

    task automatic build_number_text();
        int roll;
        int count;
        text_buf.delete();
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            count = $urandom_range(1, 6);
            repeat (count) text_buf.push_back(char_t'($urandom));
            return;
        end
        if ($urandom_range(0, 1))
        begin
            count = $urandom_range(1, 3);
            repeat (count) text_buf.push_back(random_blank());
        end
        if ($urandom_range(0, 1))
            text_buf.push_back(CH_MINUS);
        count = $urandom_range(0, 99);
        if (count < 70)
            count = $urandom_range(0, 5);
        else if (count < 90)
            count = $urandom_range(6, 8);
        else
            count = 0;
        repeat (count) text_buf.push_back(random_digit());
        if ($urandom_range(0, 99) < 65)
        begin
            text_buf.push_back(CH_DOT);
            count = $urandom_range(0, 12);
            repeat (count) text_buf.push_back(random_digit());
        end
        // Strings without an end byte are abandoned by the next one.
        if (roll < 15)
            return;
        if ($urandom_range(0, 99) < 35)
            text_buf.push_back(8'h00);
        else
            text_buf.push_back(char_t'($urandom));
        if ($urandom_range(0, 3) == 0)
        begin
            count = $urandom_range(1, 3);
            repeat (count) text_buf.push_back(char_t'($urandom));
        end
    endtask

    task automatic test_random_strings(input int char_budget);
        int stop_at;
        int next_drain;
        bit quiet;
        stop_at    = chars_sent + char_budget;
        next_drain = chars_sent + 400;
        while (chars_sent < stop_at)
        begin
            quiet           = ($urandom_range(0, 9) == 0);
            keep_text_busy  = quiet;
            keep_ready_high = quiet;
            build_number_text();
            send_text_buf();
            if (chars_sent >= next_drain)
            begin
                text_idle();
                wait_for_results();
                next_drain = chars_sent + 400;
            end
        end
        keep_text_busy  = 1'b0;
        keep_ready_high = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_numbers
        fixed_number_t want;
        if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (pending_numbers.size() == 0)
            begin
                report_mismatch($sformatf("result 0x%08h with nothing expected",
                                          result_if.value));
            end
            else
            begin
                want = pending_numbers.pop_front();
                if (result_if.value !== want.value)
                    report_mismatch($sformatf("value 0x%08h, expected 0x%08h",
                                              result_if.value, want.value));
                if (result_if.saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %b, expected %b",
                                              result_if.saturated, want.saturated));
                numbers_seen++;
                if (want.saturated)
                    saturated_seen++;
                if (want.value < 0)
                    negative_seen++;
            end
        end
    end

    initial
    begin : drive_result_ready
        int stall_left;
        stall_left      = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (keep_ready_high || stall_left == 0)
            begin
                result_if.ready = 1'b1;
                if (!keep_ready_high && $urandom_range(0, 99) < 20)
                    stall_left = random_gap();
            end
            else
            begin
                result_if.ready = 1'b0;
                stall_left--;
            end
        end
    end

    initial
    begin
        text_if.valid   = 1'b0;
        text_if.ch      = '0;
        text_if.first   = 1'b0;
        rst_n           = 1'b0;
        keep_text_busy  = 1'b0;
        keep_ready_high = 1'b0;
        error_count     = 0;
        chars_sent      = 0;
        strings_started = 0;
        numbers_seen    = 0;
        saturated_seen  = 0;
        negative_seen   = 0;
        clear_parse();
        parse_phase = PH_DONE;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_back_to_back_strings();
        test_random_strings(1350);

        text_idle();
        wait_for_results();
        repeat (8 * FRAC_BITS) @(posedge clk);

        $display("Sent %0d characters in %0d strings; checked %0d numbers,", chars_sent,
                 strings_started, numbers_seen);
        $display("%0d of them clamped and %0d negative.", saturated_seen, negative_seen);
        if (error_count == 0)
            $display("decimal_text_to_fixed_unit test passed");
        else
            $display("decimal_text_to_fixed_unit test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/dtf_pkg.sv
sv/dtf_in_if.sv
sv/dtf_out_if.sv
sv/dtf_front.sv
sv/dtf_queue.sv
sv/dtf_back.sv
sv/decimal_text_to_fixed_unit.sv
verif/decimal_text_to_fixed_unit_tb.sv
